### design/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // field widths
  localparam int HueW = 13;
  localparam int ChanW = 8;
  localparam int RemW = 10;
  localparam int SectW = 4;
  localparam int ProdW = 18;
  localparam int NumW = 26;
  localparam int PackW = 28;

  // arithmetic constants
  localparam logic [RemW-1:0] SectorSpan = 10'd960;
  localparam logic [ChanW-1:0] FullScale = 8'd255;
  // common divisor of all three channels: 255 * 960
  localparam logic [ProdW-1:0] Den = 18'd244800;
  localparam logic [PackW-1:0] PackHigh = 28'd1000000;
  localparam logic [PackW-1:0] PackMid = 28'd1000;

  // sector codes, anything above five routes like five
  localparam logic [SectW-1:0] SECT_0 = 4'd0;
  localparam logic [SectW-1:0] SECT_1 = 4'd1;
  localparam logic [SectW-1:0] SECT_2 = 4'd2;
  localparam logic [SectW-1:0] SECT_3 = 4'd3;
  localparam logic [SectW-1:0] SECT_4 = 4'd4;

  // divider lanes
  localparam int LANE_P = 0;
  localparam int LANE_Q = 1;
  localparam int LANE_T = 2;
  localparam int Lanes = 3;

  typedef logic [Lanes-1:0][NumW-1:0] num_lanes_t;
  typedef logic [Lanes-1:0][ChanW-1:0] quot_lanes_t;

  // per-stage payload of the divider
  typedef struct packed {
    num_lanes_t rem;
    quot_lanes_t quot;
    logic [SectW-1:0] sector;
    logic [ChanW-1:0] val;
  } div_data_t;

endpackage

### design/hsvrgb_divider.sv
module hsvrgb_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hsvrgb_pkg::num_lanes_t   in_num,
  input  logic [hsvrgb_pkg::SectW-1:0] in_sector,
  input  logic [hsvrgb_pkg::ChanW-1:0] in_val,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsvrgb_pkg::quot_lanes_t  out_quot,
  output logic [hsvrgb_pkg::SectW-1:0] out_sector,
  output logic [hsvrgb_pkg::ChanW-1:0] out_val
);

  // two quotient bits per stage
  localparam int Stages = hsvrgb_pkg::ChanW / 2;

  logic                   valid_r [Stages];
  hsvrgb_pkg::div_data_t  data_r  [Stages];
  hsvrgb_pkg::div_data_t  data_nxt [Stages];
  logic                   adv     [Stages+1];

  hsvrgb_pkg::div_data_t  head;

  always_comb begin
    head.rem = in_num;
    head.quot = '0;
    head.sector = in_sector;
    head.val = in_val;
  end

  assign adv[Stages] = out_ready;

  for (genvar j = 0; j < Stages; j++) begin : g_stage
    localparam int HiBit = hsvrgb_pkg::ChanW - 1 - 2 * j;

    assign adv[j] = !valid_r[j] || adv[j+1];

    always_comb begin
      logic [hsvrgb_pkg::NumW-1:0] dhi;
      logic [hsvrgb_pkg::NumW-1:0] dlo;
      hsvrgb_pkg::div_data_t src;
      dhi = hsvrgb_pkg::NumW'(hsvrgb_pkg::Den) << HiBit;
      dlo = hsvrgb_pkg::NumW'(hsvrgb_pkg::Den) << (HiBit - 1);
      src = (j == 0) ? head : data_r[(j == 0) ? 0 : j - 1];
      data_nxt[j] = src;
      for (int l = 0; l < hsvrgb_pkg::Lanes; l++) begin
        if (data_nxt[j].rem[l] >= dhi) begin
          data_nxt[j].rem[l] = data_nxt[j].rem[l] - dhi;
          data_nxt[j].quot[l][HiBit] = 1'b1;
        end
        if (data_nxt[j].rem[l] >= dlo) begin
          data_nxt[j].rem[l] = data_nxt[j].rem[l] - dlo;
          data_nxt[j].quot[l][HiBit-1] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (adv[j]) begin
        valid_r[j] <= (j == 0) ? in_valid : valid_r[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        data_r[j] <= data_nxt[j];
      end
    end
  end

  assign in_ready   = adv[0];
  assign out_valid  = valid_r[Stages-1];
  assign out_quot   = data_r[Stages-1].quot;
  assign out_sector = data_r[Stages-1].sector;
  assign out_val    = data_r[Stages-1].val;

endmodule

### design/hsv_to_rgb_converter.sv
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall   hue[13], saturation[8], brightness[8]
// out_     output     out_valid / out_stall red[8], green[8], blue[8], decimal_packed[28]
//
// one request per clock unless in_stall is high, through eight register stages
// the restoring divider takes two quotient bits in each of four stages
// rst_n is synchronous and clears every valid bit, payload registers keep their data
// a stall on the output only holds the stages that carry a request, bubbles still
// close up, so in_stall rises only once every stage is full
module hsv_to_rgb_converter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hsvrgb_pkg::HueW-1:0]          in_hue,
  input  logic [hsvrgb_pkg::ChanW-1:0]         in_saturation,
  input  logic [hsvrgb_pkg::ChanW-1:0]         in_brightness,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hsvrgb_pkg::ChanW-1:0]         out_red,
  output logic [hsvrgb_pkg::ChanW-1:0]         out_green,
  output logic [hsvrgb_pkg::ChanW-1:0]         out_blue,
  output logic [hsvrgb_pkg::PackW-1:0]         out_decimal_packed
);

  // ---------------------------------------------------------------------
  // advance chain: a stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic adv1, adv2, adv3, adv_out;
  logic div_in_ready, div_out_valid;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv3     = !s3_valid_r || div_in_ready;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  // ---------------------------------------------------------------------
  // stage 1: split hue into sector (hue / 960) and fraction (hue mod 960)
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::SectW-1:0] s1_sector_r, s1_sector_nxt;
  logic [hsvrgb_pkg::RemW-1:0]  s1_rem_r, s1_rem_nxt;
  logic [hsvrgb_pkg::ChanW-1:0] s1_sat_r, s1_val_r;

  always_comb begin
    logic [hsvrgb_pkg::HueW-1:0] base;
    s1_sector_nxt = '0;
    // independent compares against every sector boundary, count the ones passed
    for (int k = 1; k <= 8; k++) begin
      if (in_hue >= hsvrgb_pkg::HueW'(k) * hsvrgb_pkg::HueW'(hsvrgb_pkg::SectorSpan)) begin
        s1_sector_nxt = s1_sector_nxt + hsvrgb_pkg::SectW'(1);
      end
    end
    base = hsvrgb_pkg::HueW'(s1_sector_nxt) * hsvrgb_pkg::HueW'(hsvrgb_pkg::SectorSpan);
    s1_rem_nxt = hsvrgb_pkg::RemW'(in_hue - base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_sector_r <= s1_sector_nxt;
      s1_rem_r    <= s1_rem_nxt;
      s1_sat_r    <= in_saturation;
      s1_val_r    <= in_brightness;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: saturation products, all on the 255*960 scale
  //   sq = s * f, st = s * (960 - f), sp = (255 - s) * 960
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::ProdW-1:0] s2_sq_r, s2_st_r, s2_sp_r;
  logic [hsvrgb_pkg::ProdW-1:0] s2_sq_nxt, s2_st_nxt, s2_sp_nxt;
  logic [hsvrgb_pkg::SectW-1:0] s2_sector_r;
  logic [hsvrgb_pkg::ChanW-1:0] s2_val_r;

  always_comb begin
    logic [hsvrgb_pkg::RemW-1:0]  rem_inv;
    logic [hsvrgb_pkg::ChanW-1:0] sat_inv;
    rem_inv   = hsvrgb_pkg::SectorSpan - s1_rem_r;
    sat_inv   = hsvrgb_pkg::FullScale - s1_sat_r;
    s2_sq_nxt = hsvrgb_pkg::ProdW'(s1_sat_r) * hsvrgb_pkg::ProdW'(s1_rem_r);
    s2_st_nxt = hsvrgb_pkg::ProdW'(s1_sat_r) * hsvrgb_pkg::ProdW'(rem_inv);
    s2_sp_nxt = hsvrgb_pkg::ProdW'(sat_inv) * hsvrgb_pkg::ProdW'(hsvrgb_pkg::SectorSpan);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_sq_r     <= s2_sq_nxt;
      s2_st_r     <= s2_st_nxt;
      s2_sp_r     <= s2_sp_nxt;
      s2_sector_r <= s1_sector_r;
      s2_val_r    <= s1_val_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: numerators, value times the scaled weight
  //   p, q and t all divide by 255*960 afterwards
  // ---------------------------------------------------------------------
  hsvrgb_pkg::num_lanes_t       s3_num_r, s3_num_nxt;
  logic [hsvrgb_pkg::SectW-1:0] s3_sector_r;
  logic [hsvrgb_pkg::ChanW-1:0] s3_val_r;

  always_comb begin
    logic [hsvrgb_pkg::ProdW-1:0] wq;
    logic [hsvrgb_pkg::ProdW-1:0] wt;
    wq = hsvrgb_pkg::Den - s2_sq_r;
    wt = hsvrgb_pkg::Den - s2_st_r;
    s3_num_nxt[hsvrgb_pkg::LANE_P] =
      hsvrgb_pkg::NumW'(s2_val_r) * hsvrgb_pkg::NumW'(s2_sp_r);
    s3_num_nxt[hsvrgb_pkg::LANE_Q] =
      hsvrgb_pkg::NumW'(s2_val_r) * hsvrgb_pkg::NumW'(wq);
    s3_num_nxt[hsvrgb_pkg::LANE_T] =
      hsvrgb_pkg::NumW'(s2_val_r) * hsvrgb_pkg::NumW'(wt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv3) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_num_r    <= s3_num_nxt;
      s3_sector_r <= s2_sector_r;
      s3_val_r    <= s2_val_r;
    end
  end

  // ---------------------------------------------------------------------
  // stages 4 to 7: pipelined divide by 255*960, quotients fit in 8 bits
  // ---------------------------------------------------------------------
  hsvrgb_pkg::quot_lanes_t      div_quot;
  logic [hsvrgb_pkg::SectW-1:0] div_sector;
  logic [hsvrgb_pkg::ChanW-1:0] div_val;

  hsvrgb_divider u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s3_valid_r),
    .in_ready   (div_in_ready),
    .in_num     (s3_num_r),
    .in_sector  (s3_sector_r),
    .in_val     (s3_val_r),
    .out_valid  (div_out_valid),
    .out_ready  (adv_out),
    .out_quot   (div_quot),
    .out_sector (div_sector),
    .out_val    (div_val)
  );

  // ---------------------------------------------------------------------
  // stage 8: route p, q, t, v by sector and form the decimal word
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::ChanW-1:0] red_r, green_r, blue_r;
  logic [hsvrgb_pkg::ChanW-1:0] red_nxt, green_nxt, blue_nxt;
  logic [hsvrgb_pkg::PackW-1:0] packed_r, packed_nxt;

  always_comb begin
    logic [hsvrgb_pkg::ChanW-1:0] pch;
    logic [hsvrgb_pkg::ChanW-1:0] qch;
    logic [hsvrgb_pkg::ChanW-1:0] tch;
    pch = div_quot[hsvrgb_pkg::LANE_P];
    qch = div_quot[hsvrgb_pkg::LANE_Q];
    tch = div_quot[hsvrgb_pkg::LANE_T];
    case (div_sector)
      hsvrgb_pkg::SECT_0: begin
        red_nxt = div_val; green_nxt = tch; blue_nxt = pch;
      end
      hsvrgb_pkg::SECT_1: begin
        red_nxt = qch; green_nxt = div_val; blue_nxt = pch;
      end
      hsvrgb_pkg::SECT_2: begin
        red_nxt = pch; green_nxt = div_val; blue_nxt = tch;
      end
      hsvrgb_pkg::SECT_3: begin
        red_nxt = pch; green_nxt = qch; blue_nxt = div_val;
      end
      hsvrgb_pkg::SECT_4: begin
        red_nxt = tch; green_nxt = pch; blue_nxt = div_val;
      end
      // sector five and out-of-range hue
      default: begin
        red_nxt = div_val; green_nxt = pch; blue_nxt = qch;
      end
    endcase
    // constant multiplies only, synthesis turns these into shift-add trees
    packed_nxt = hsvrgb_pkg::PackW'(red_nxt) * hsvrgb_pkg::PackHigh
               + hsvrgb_pkg::PackW'(green_nxt) * hsvrgb_pkg::PackMid
               + hsvrgb_pkg::PackW'(blue_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      packed_r <= packed_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_decimal_packed = packed_r;

endmodule

### bench/hsv_to_rgb_converter_test.sv
module hsv_to_rgb_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one pixel request as the sender offers it
  typedef struct {
    logic [hsvrgb_pkg::HueW-1:0]  hue;
    logic [hsvrgb_pkg::ChanW-1:0] sat;
    logic [hsvrgb_pkg::ChanW-1:0] val;
    bit                           settle;  // hold back until every result so far has come
  } pixel_req_t;

  // one converted pixel
  typedef struct {
    logic [hsvrgb_pkg::ChanW-1:0] red;
    logic [hsvrgb_pkg::ChanW-1:0] green;
    logic [hsvrgb_pkg::ChanW-1:0] blue;
    logic [hsvrgb_pkg::PackW-1:0] dec_word;
  } rgb_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [hsvrgb_pkg::HueW-1:0]  in_hue = '0;
  logic [hsvrgb_pkg::ChanW-1:0] in_saturation = '0;
  logic [hsvrgb_pkg::ChanW-1:0] in_brightness = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [hsvrgb_pkg::ChanW-1:0] out_red;
  logic [hsvrgb_pkg::ChanW-1:0] out_green;
  logic [hsvrgb_pkg::ChanW-1:0] out_blue;
  logic [hsvrgb_pkg::PackW-1:0] out_decimal_packed;

  hsv_to_rgb_converter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_hue             (in_hue),
    .in_saturation      (in_saturation),
    .in_brightness      (in_brightness),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_decimal_packed (out_decimal_packed)
  );

  // pixels waiting to be offered, and converted pixels waiting to come out
  pixel_req_t pixel_queue[$];
  rgb_pixel_t rgb_expected[$];
  pixel_req_t next_req;

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned errors = 0;

  // request taken at the last rising edge, read by the driver at the falling edge
  bit in_took = 1'b0;

  // sender pacing
  int unsigned tx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          tx_no_gaps = 1'b0;

  // receiver pacing, the long hold-off is asked for by the main sequence
  int unsigned rx_hold_left = 0;
  int unsigned rx_hold_len = 0;
  int unsigned rx_hold_max = 0;
  bit          rx_hold_req = 1'b0;
  bit          rx_calm = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // hsv to rgb with exact integer arithmetic, every channel truncated
  function automatic rgb_pixel_t hsv_pixel_to_rgb(logic [hsvrgb_pkg::HueW-1:0] hue,
                                                  logic [hsvrgb_pkg::ChanW-1:0] sat,
                                                  logic [hsvrgb_pkg::ChanW-1:0] val);
    int unsigned                  v, s, frac, span, full, den, pch, qch, tch, r, g, b;
    logic [hsvrgb_pkg::SectW-1:0] sector;
    rgb_pixel_t                   px;
    v = 32'(val);
    s = 32'(sat);
    span = 32'(hsvrgb_pkg::SectorSpan);
    full = 32'(hsvrgb_pkg::FullScale);
    den = 32'(hsvrgb_pkg::Den);
    sector = hsvrgb_pkg::SectW'(32'(hue) / span);
    frac = 32'(hue) % span;
    // p = v(1-s), q = v(1-s*f), t = v(1-s(1-f)), all scaled by 255
    pch = v * (full - s) / full;
    qch = v * (den - s * frac) / den;
    tch = v * (den - s * (span - frac)) / den;
    case (sector)
      hsvrgb_pkg::SECT_0: begin r = v;   g = tch; b = pch; end
      hsvrgb_pkg::SECT_1: begin r = qch; g = v;   b = pch; end
      hsvrgb_pkg::SECT_2: begin r = pch; g = v;   b = tch; end
      hsvrgb_pkg::SECT_3: begin r = pch; g = qch; b = v;   end
      hsvrgb_pkg::SECT_4: begin r = tch; g = pch; b = v;   end
      // sector five and any hue past 360 degrees
      default: begin r = v;   g = pch; b = qch; end
    endcase
    px.red = r[hsvrgb_pkg::ChanW-1:0];
    px.green = g[hsvrgb_pkg::ChanW-1:0];
    px.blue = b[hsvrgb_pkg::ChanW-1:0];
    px.dec_word = hsvrgb_pkg::PackW'(r * 32'(hsvrgb_pkg::PackHigh)
                                     + g * 32'(hsvrgb_pkg::PackMid) + b);
    return px;
  endfunction

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_pixel(logic [hsvrgb_pkg::HueW-1:0] hue,
                             logic [hsvrgb_pkg::ChanW-1:0] sat,
                             logic [hsvrgb_pkg::ChanW-1:0] val, bit settle);
    pixel_req_t req;
    req.hue = hue;
    req.sat = sat;
    req.val = val;
    req.settle = settle;
    pixel_queue.push_back(req);
    queued_total++;
  endtask

  // random pixel weighted toward sector edges, extremes and out-of-range hues
  task automatic queue_random_pixel(bit settle);
    int unsigned                  pick;
    logic [hsvrgb_pkg::HueW-1:0]  hue;
    logic [hsvrgb_pkg::ChanW-1:0] sat, val;
    pick = $urandom_range(0, 99);
    if (pick < 50) hue = hsvrgb_pkg::HueW'($urandom_range(0, 5759));
    else if (pick < 65) begin
      hue = hsvrgb_pkg::HueW'($urandom_range(0, 8) * 960 + $urandom_range(0, 4) - 2);
    end
    else if (pick < 80) hue = hsvrgb_pkg::HueW'($urandom_range(0, 8191));
    else if (pick < 90) hue = hsvrgb_pkg::HueW'($urandom_range(5760, 8191));
    else hue = ($urandom_range(0, 1) != 0) ? hsvrgb_pkg::HueW'(5759) : hsvrgb_pkg::HueW'(0);
    pick = $urandom_range(0, 99);
    sat = (pick < 70) ? hsvrgb_pkg::ChanW'($urandom) : (pick < 85) ? '0 : '1;
    pick = $urandom_range(0, 99);
    val = (pick < 70) ? hsvrgb_pkg::ChanW'($urandom) : (pick < 85) ? '0 : '1;
    queue_pixel(hue, sat, val, settle);
  endtask

  // idle means every queued request is in and every result is out
  task automatic wait_drained();
    while (accepted_total != queued_total || rgb_expected.size() != 0) @(posedge clk);
  endtask

  task automatic check_channel(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // monitor: results checked before new requests are predicted
  always @(posedge clk) begin
    rgb_pixel_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_expected.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %0d",
                   $realtime, out_decimal_packed);
          errors++;
        end else begin
          want = rgb_expected.pop_front();
          check_channel("red", 32'(want.red), 32'(out_red));
          check_channel("green", 32'(want.green), 32'(out_green));
          check_channel("blue", 32'(want.blue), 32'(out_blue));
          check_channel("decimal_packed", 32'(want.dec_word), 32'(out_decimal_packed));
          checked_total++;
        end
      end
      if (in_valid && in_stall) backpressure_cycles++;
      if (in_valid && !in_stall) begin
        rgb_expected.push_back(hsv_pixel_to_rgb(in_hue, in_saturation, in_brightness));
        accepted_total++;
        in_took = 1'b1;
      end
    end
  end

  // driver: a request stays on the port until taken, then the next one or a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0 && !tx_no_gaps) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pixel_queue.size() > 0 &&
                   !(pixel_queue[0].settle && rgb_expected.size() != 0)) begin
        next_req = pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_hue <= next_req.hue;
        in_saturation <= next_req.sat;
        in_brightness <= next_req.val;
        // stretches with no gaps at all come and go
        if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
        tx_gap <= (tx_calm || tx_no_gaps) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, quiet stretches, and the long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = rx_hold_len;
      rx_hold_req = 1'b0;
      if (rx_hold_len > rx_hold_max) rx_hold_max = rx_hold_len;
    end
    if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      rx_hold_left = idle_len();
      if (rx_hold_left > 0) rx_hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: sector edges, every sector, hue past 360, saturation and value extremes
    queue_pixel(13'd0, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd0, 8'd0, 8'd255, 1'b0);
    queue_pixel(13'd0, 8'd255, 8'd0, 1'b0);
    queue_pixel(13'd959, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd960, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd1919, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd1920, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd2400, 8'd128, 8'd200, 1'b0);
    queue_pixel(13'd2880, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd3839, 8'd1, 8'd254, 1'b0);
    queue_pixel(13'd3840, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd4320, 8'd77, 8'd131, 1'b0);
    queue_pixel(13'd4800, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd5759, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd5759, 8'd0, 8'd0, 1'b0);
    // hue past 360 degrees routes like the last sector
    queue_pixel(13'd5760, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd6720, 8'd200, 8'd180, 1'b0);
    queue_pixel(13'd7679, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd7680, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd8191, 8'd255, 8'd255, 1'b0);
    queue_pixel(13'd8191, 8'd170, 8'd85, 1'b0);
    queue_pixel(13'd480, 8'd170, 8'd85, 1'b0);
    wait_drained();

    // long receiver hold-off while the sender keeps offering, so the pipe fills
    rx_hold_len = 120;
    rx_hold_req = 1'b1;
    tx_no_gaps = 1'b1;
    repeat (40) queue_random_pixel(1'b0);
    while (accepted_total != queued_total) @(posedge clk);
    tx_no_gaps = 1'b0;

    // random traffic, now and then a request that waits for the pipe to empty
    repeat (1240) queue_random_pixel($urandom_range(0, 149) == 0);
    wait_drained();

    // let any stray result show up after the pipe has drained
    repeat (24) @(posedge clk);
    $display("covered %0d pixel requests across all sectors, edges and hues past 360",
             accepted_total);
    $display("checked %0d results, %0d input stall cycles, longest hold-off %0d cycles",
             checked_total, backpressure_cycles, rx_hold_max);
    if (errors == 0) begin
      $display("[hsv_to_rgb_converter] OK");
    end else begin
      $display("[hsv_to_rgb_converter] ERROR");
    end
    $finish;
  end

  // watchdog, far past the slowest legal run
  initial begin
    #2000000;
    $display("[hsv_to_rgb_converter] ERROR");
    $finish;
  end

endmodule
